// ===== design/mmwd_pkg.sv =====
// Shared types, constants and tables of the memory map write decoder.
`timescale 1ns / 1ps
`default_nettype none
package mmwd_pkg;

   localparam int unsigned ADDR_W   = 16;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned OP_W     = 2;
   localparam int unsigned PERIOD_W = 11;
   localparam int unsigned MAP_DEPTH = 65536;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // Operation codes on the request channel; code 3 is unused.
   typedef enum logic [OP_W-1:0] {
      OP_READ    = 2'd0,
      OP_DECODED = 2'd1,
      OP_RAW     = 2'd2
   } op_type;

   // Special addresses and address windows of the map.
   localparam logic [ADDR_W-1:0] ADDR_DIVIDER  = 16'hFF04;
   localparam logic [ADDR_W-1:0] ADDR_TIMERCTL = 16'hFF07;
   localparam logic [ADDR_W-1:0] ADDR_LINE     = 16'hFF44;
   localparam logic [ADDR_W-1:0] ADDR_DMA      = 16'hFF46;
   localparam logic [ADDR_W-1:0] ROM_END       = 16'h8000;
   localparam logic [ADDR_W-1:0] ECHO_LO       = 16'hE000;
   localparam logic [ADDR_W-1:0] ECHO_LAST     = 16'hFDFF;
   localparam logic [ADDR_W-1:0] ECHO_OFFSET   = 16'h2000;
   localparam logic [ADDR_W-1:0] SPRITE_BASE   = 16'hFE00;
   localparam logic [ADDR_W-1:0] LOCK_LO       = 16'hFEA0;
   localparam logic [ADDR_W-1:0] LOCK_LAST     = 16'hFEFE;
   localparam logic [7:0]        SPRITE_LEN    = 8'hA0;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd1024;

   // Power-up contents of the I/O registers.
   localparam int unsigned INIT_COUNT = 32;
   localparam int unsigned INIT_W     = $clog2(INIT_COUNT);

   localparam logic [ADDR_W-1:0] INIT_ADDR [INIT_COUNT] = '{
      16'hFF05, 16'hFF06, 16'hFF07, 16'hFF10, 16'hFF11, 16'hFF12, 16'hFF14, 16'hFF16,
      16'hFF17, 16'hFF19, 16'hFF1A, 16'hFF1B, 16'hFF1C, 16'hFF1E, 16'hFF20, 16'hFF21,
      16'hFF22, 16'hFF23, 16'hFF24, 16'hFF25, 16'hFF26, 16'hFF40, 16'hFF42, 16'hFF43,
      16'hFF44, 16'hFF45, 16'hFF47, 16'hFF48, 16'hFF49, 16'hFF4A, 16'hFF4B, 16'hFFFF
   };

   localparam logic [DATA_W-1:0] INIT_VAL [INIT_COUNT] = '{
      8'h00, 8'h00, 8'h00, 8'h80, 8'hBF, 8'hF3, 8'hBF, 8'h3F,
      8'h00, 8'hBF, 8'h7F, 8'hFF, 8'h9F, 8'hBF, 8'hFF, 8'h00,
      8'h00, 8'hBF, 8'h77, 8'hF3, 8'hF1, 8'h91, 8'h00, 8'h00,
      8'h90, 8'h00, 8'hFC, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00
   };

   // What the back end has to do for one item.
   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_READ,
      CMD_STORE,
      CMD_ECHO,
      CMD_TIMER,
      CMD_DMA
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [ADDR_W-1:0]       address;
      logic [DATA_W-1:0]       data;
   } cmd_type;

   // Timer tick period selected by the low two bits of the control byte.
   function automatic logic [PERIOD_W-1:0] period_of(input logic [1:0] sel);
      logic [PERIOD_W-1:0] p;
      case (sel)
         2'd0:    p = 11'd1024;
         2'd1:    p = 11'd16;
         2'd2:    p = 11'd64;
         default: p = 11'd256;
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

// ===== design/mmwd_if.sv =====
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
`default_nettype none
interface mmwd_req_if;
   import mmwd_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output operation, output address, output write_data,
                   input ready);
   modport sink   (input valid, input operation, input address, input write_data,
                   output ready);
endinterface

interface mmwd_rsp_if;
   import mmwd_pkg::*;

   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   read_data;
   logic [PERIOD_W-1:0] timer_period;
   logic                period_changed;

   modport source (output valid, output read_data, output timer_period,
                   output period_changed, input ready);
   modport sink   (input valid, input read_data, input timer_period,
                   input period_changed, output ready);
endinterface
`default_nettype wire

// ===== design/handheld_memory_map_write_decoder_top.sv =====
// Top level of the memory map write decoder.
//
// Requests arrive on req (operation, address, write_data); every accepted item
// produces exactly one response item on rsp (read_data, timer_period,
// period_changed), in request order.
// The front end decodes each item and places it in a small command queue, so
// req.ready stays high until the queue is full; the back end executes commands
// against a dual-port 64 KiB memory (one write, one registered read a cycle).
// A plain write, timer write or ignored access is answered from ST_IDLE; a read or an
// echo-area write passes through ST_READ or ST_ECHO first, and a DMA write through
// ST_DMA, whose 160-byte copy moves one byte a cycle.
// Plain writes are taken one item a cycle while the response register is free; no new
// item is taken while a read, echo write or DMA write is still in progress.
// After reset the back end loads the 32 I/O power-up values in ST_INIT;
// items taken meanwhile wait in the queue. Reset also sets the timer period
// to 1024. When rsp.ready is low the response register holds its item and the
// back end stops, and the queue fills until req.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module handheld_memory_map_write_decoder_top #(
   parameter int unsigned QUEUE_DEPTH = mmwd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mmwd_req_if.sink   req,
   mmwd_rsp_if.source rsp
);
   import mmwd_pkg::*;

   logic    push;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   cmd_type push_cmd;
   cmd_type head_cmd;

   mmwd_front u_front (
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   mmwd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   mmwd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule
`default_nettype wire

// ===== design/mmwd_front.sv =====
// Front end: accepts request items and decodes them into back-end commands.
`timescale 1ns / 1ps
`default_nettype none
module mmwd_front (
   mmwd_req_if.sink          req,
   input  wire logic         queue_full,
   output logic              push,
   output mmwd_pkg::cmd_type cmd
);
   import mmwd_pkg::*;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      cmd.kind    = CMD_NOP;
      cmd.address = req.address;
      cmd.data    = req.write_data;
      case (req.operation)
         OP_READ: begin
            cmd.kind = CMD_READ;
         end
         OP_RAW: begin
            cmd.kind = CMD_STORE;
         end
         OP_DECODED: begin
            if (req.address == ADDR_LINE || req.address == ADDR_DIVIDER) begin
               cmd.kind = CMD_STORE;
               cmd.data = '0;
            end else if (req.address == ADDR_DMA) begin
               cmd.kind = CMD_DMA;
            end else if (req.address == ADDR_TIMERCTL) begin
               cmd.kind = CMD_TIMER;
            end else if (req.address < ROM_END) begin
               cmd.kind = CMD_NOP;
            end else if (req.address inside {[ECHO_LO:ECHO_LAST]}) begin
               cmd.kind = CMD_ECHO;
            end else if (req.address inside {[LOCK_LO:LOCK_LAST]}) begin
               cmd.kind = CMD_NOP;
            end else begin
               cmd.kind = CMD_STORE;
            end
         end
         default: begin
            cmd.kind = CMD_NOP;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== design/mmwd_queue.sv =====
// Command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module mmwd_queue #(
   parameter int unsigned DEPTH = mmwd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mmwd_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output mmwd_pkg::cmd_type      head_cmd
);
   import mmwd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   cmd_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== design/mmwd_back.sv =====
// Back end: owns the 64 KiB map memory and the timer period, executes commands.
`timescale 1ns / 1ps
`default_nettype none
module mmwd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire mmwd_pkg::cmd_type head_cmd,
   output logic                   pop,
   mmwd_rsp_if.source             rsp
);
   import mmwd_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_ECHO,
      ST_DMA
   } state_type;

   logic [DATA_W-1:0] map_ff [MAP_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   state_type           state_ff, state_in;
   logic [INIT_W-1:0]   init_cnt_ff, init_cnt_in;
   cmd_type             cmd_ff, cmd_in;
   logic [7:0]          dma_cnt_ff, dma_cnt_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [PERIOD_W-1:0] rsp_period_ff, rsp_period_in;
   logic                rsp_changed_ff, rsp_changed_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic [7:0]          dma_wr_low;
   logic                slot_free;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.read_data      = rsp_data_ff;
   assign rsp.timer_period   = rsp_period_ff;
   assign rsp.period_changed = rsp_changed_ff;

   // The response register is free next cycle if it is empty or being drained now.
   assign slot_free  = !rsp_valid_ff || rsp.ready;
   assign dma_wr_low = dma_cnt_ff - 8'd1;

   always_comb begin
      state_in       = state_ff;
      init_cnt_in    = init_cnt_ff;
      cmd_in         = cmd_ff;
      dma_cnt_in     = dma_cnt_ff;
      period_in      = period_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_data_in    = rsp_data_ff;
      rsp_period_in  = rsp_period_ff;
      rsp_changed_in = rsp_changed_ff;
      wr_en          = 1'b0;
      wr_addr        = head_cmd.address;
      wr_data        = head_cmd.data;
      rd_addr        = head_cmd.address;
      pop            = 1'b0;

      case (state_ff)
         ST_INIT: begin
            wr_en       = 1'b1;
            wr_addr     = INIT_ADDR[init_cnt_ff];
            wr_data     = INIT_VAL[init_cnt_ff];
            init_cnt_in = init_cnt_ff + 1'b1;
            if (init_cnt_ff == INIT_W'(INIT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid && slot_free) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               case (head_cmd.kind)
                  CMD_READ: begin
                     state_in = ST_READ;
                  end
                  CMD_STORE: begin
                     wr_en          = 1'b1;
                     rsp_valid_in   = 1'b1;
                     rsp_data_in    = '0;
                     rsp_period_in  = period_ff;
                     rsp_changed_in = 1'b0;
                  end
                  CMD_ECHO: begin
                     wr_en    = 1'b1;
                     state_in = ST_ECHO;
                  end
                  CMD_TIMER: begin
                     wr_en          = 1'b1;
                     period_in      = period_of(head_cmd.data[1:0]);
                     rsp_valid_in   = 1'b1;
                     rsp_data_in    = '0;
                     rsp_period_in  = period_in;
                     rsp_changed_in = (period_in != period_ff);
                  end
                  CMD_DMA: begin
                     dma_cnt_in = '0;
                     state_in   = ST_DMA;
                  end
                  default: begin
                     rsp_valid_in   = 1'b1;
                     rsp_data_in    = '0;
                     rsp_period_in  = period_ff;
                     rsp_changed_in = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in   = 1'b1;
            rsp_data_in    = rd_data_ff;
            rsp_period_in  = period_ff;
            rsp_changed_in = 1'b0;
            state_in       = ST_IDLE;
         end
         ST_ECHO: begin
            wr_en          = 1'b1;
            wr_addr        = cmd_ff.address - ECHO_OFFSET;
            wr_data        = cmd_ff.data;
            rsp_valid_in   = 1'b1;
            rsp_data_in    = '0;
            rsp_period_in  = period_ff;
            rsp_changed_in = 1'b0;
            state_in       = ST_IDLE;
         end
         ST_DMA: begin
            // Read byte k of the source page while the byte read last cycle is stored.
            rd_addr = {cmd_ff.data, dma_cnt_ff};
            if (dma_cnt_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = {SPRITE_BASE[15:8], dma_wr_low};
               wr_data = rd_data_ff;
            end
            if (dma_cnt_ff == SPRITE_LEN) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = '0;
               rsp_period_in  = period_ff;
               rsp_changed_in = 1'b0;
               state_in       = ST_IDLE;
            end else begin
               dma_cnt_in = dma_cnt_ff + 8'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
         dma_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
         dma_cnt_ff   <= dma_cnt_in;
      end
      cmd_ff         <= cmd_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_period_ff  <= rsp_period_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the memory map write decoder top level.
`timescale 1ns / 1ps
module testbench;
   import mmwd_pkg::*;

   localparam int          CLOCK_PERIOD   = 10;
   localparam int          RESET_CYCLES   = 8;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          DRAIN_CYCLES   = 200;
   localparam int          IDLE_PERCENT   = 36;
   localparam int          RANDOM_ITEMS   = 500;
   localparam int          STEADY_ITEMS   = 220;
   localparam int          STALL_ITEMS    = 60;
   localparam int          STALL_CYCLES   = 400;
   localparam logic [1:0]  OP_UNUSED      = 2'd3;

   localparam logic [PERIOD_W-1:0] TICK_PERIOD [4] = '{11'd1024, 11'd16, 11'd64, 11'd256};

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic [PERIOD_W-1:0] timer_period;
      logic                period_changed;
   } access_result_type;

   logic clock = 1'b0;
   logic reset;

   mmwd_req_if req_bus ();
   mmwd_rsp_if rsp_bus ();

   handheld_memory_map_write_decoder_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Predicted contents of the map, with a flag for every byte that holds a defined value.
   logic [DATA_W-1:0]   mem_image [MAP_DEPTH];
   bit                  mem_known [MAP_DEPTH];
   logic [ADDR_W-1:0]   known_addrs [$];
   logic [PERIOD_W-1:0] period_now;

   access_result_type pending_responses [$];

   bit req_idle_on  = 1'b1;
   bit rsp_idle_on  = 1'b1;
   int hold_cycles  = 0;
   int mismatch_count = 0;
   int accepted_count = 0;
   int read_count     = 0;
   int dma_count      = 0;
   int change_count   = 0;
   int stall_cycles   = 0;

   function automatic void store_byte(input logic [ADDR_W-1:0] addr,
                                      input logic [DATA_W-1:0] value, input bit known);
      mem_image[addr] = value;
      if (known && !mem_known[addr]) known_addrs.push_back(addr);
      mem_known[addr] = known;
   endfunction

   // Applies one access to the predicted map and returns the response it must produce.
   function automatic access_result_type decode_access(input logic [1:0] op,
                                                       input logic [ADDR_W-1:0] addr,
                                                       input logic [DATA_W-1:0] data);
      access_result_type   res;
      logic [ADDR_W-1:0]   from_addr;
      logic [PERIOD_W-1:0] p;
      int                  k;
      res = '0;
      case (op)
         OP_READ: begin
            res.read_data = mem_image[addr];
            read_count++;
         end
         OP_DECODED: begin
            if (addr == ADDR_LINE || addr == ADDR_DIVIDER) begin
               store_byte(addr, 8'h00, 1'b1);
            end else if (addr == ADDR_DMA) begin
               // The copy runs in ascending order, so overlapping sources see earlier bytes.
               for (k = 0; k < SPRITE_LEN; k++) begin
                  from_addr = {data, 8'h00} + k[ADDR_W-1:0];
                  store_byte(SPRITE_BASE + k[ADDR_W-1:0], mem_image[from_addr],
                             mem_known[from_addr]);
               end
               dma_count++;
            end else if (addr == ADDR_TIMERCTL) begin
               p = TICK_PERIOD[data[1:0]];
               store_byte(addr, data, 1'b1);
               if (p != period_now) begin
                  period_now = p;
                  res.period_changed = 1'b1;
                  change_count++;
               end
            end else if (addr < ROM_END) begin
            end else if (addr >= ECHO_LO && addr <= ECHO_LAST) begin
               store_byte(addr, data, 1'b1);
               store_byte(addr - ECHO_OFFSET, data, 1'b1);
            end else if (addr >= LOCK_LO && addr <= LOCK_LAST) begin
            end else begin
               store_byte(addr, data, 1'b1);
            end
         end
         OP_RAW: store_byte(addr, data, 1'b1);
         default: ;
      endcase
      res.timer_period = period_now;
      return res;
   endfunction

   // True when every byte that a DMA copy from this page reads holds a defined value.
   function automatic bit page_known(input logic [DATA_W-1:0] src);
      logic [ADDR_W-1:0] from_addr;
      bit                all_known;
      int                k;
      all_known = 1'b1;
      for (k = 0; k < SPRITE_LEN; k++) begin
         from_addr = {src, 8'h00} + k[ADDR_W-1:0];
         if (!mem_known[from_addr]) all_known = 1'b0;
      end
      return all_known;
   endfunction

   // Offers one item, idling at random first, and records its response once accepted.
   task automatic send_access(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
      while (req_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.address    <= addr;
      req_bus.write_data <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_responses.push_back(decode_access(op, addr, data));
      accepted_count++;
   endtask

   // Address with a defined value; the power-up registers are always defined.
   function automatic logic [ADDR_W-1:0] pick_known_address();
      logic [ADDR_W-1:0] a;
      a = INIT_ADDR[INIT_W'($urandom_range(INIT_COUNT - 1))];
      if (known_addrs.size() > 0 && $urandom_range(9) < 8) begin
         a = known_addrs[$urandom_range(known_addrs.size() - 1)];
         if (!mem_known[a]) a = INIT_ADDR[INIT_W'($urandom_range(INIT_COUNT - 1))];
      end
      return a;
   endfunction

   // Address spread over the windows of the map; the DMA register only when allowed.
   function automatic logic [ADDR_W-1:0] pick_address(input bit allow_dma);
      logic [ADDR_W-1:0] a;
      case ($urandom_range(9))
         0:       a = ADDR_W'($urandom_range(16'hFFFF));
         1:       a = ADDR_W'($urandom_range(16'h7FFF));
         2:       a = ADDR_W'(16'hC000 + $urandom_range(255));
         3:       a = ADDR_W'(16'h8000 + $urandom_range(16'h5FFF));
         4:       a = ADDR_W'(16'hE000 + $urandom_range(255));
         5:       a = ADDR_W'(ECHO_LO + $urandom_range(ECHO_LAST - ECHO_LO));
         6:       a = ADDR_W'(SPRITE_BASE + $urandom_range(SPRITE_LEN - 1));
         7:       a = ADDR_W'(LOCK_LO + $urandom_range(16'h5F));
         8:       a = ADDR_W'(16'hFF00 + $urandom_range(255));
         default: begin
            case ($urandom_range(2))
               0:       a = ADDR_DIVIDER;
               1:       a = ADDR_LINE;
               default: a = ADDR_TIMERCTL;
            endcase
         end
      endcase
      if (a == ADDR_DMA && !allow_dma) a = ADDR_LINE;
      return a;
   endfunction

   task automatic random_access();
      int                r;
      logic [DATA_W-1:0] src;
      r = $urandom_range(99);
      if (r < 35) begin
         send_access(OP_READ, pick_known_address(), DATA_W'($urandom_range(255)));
      end else if (r < 75) begin
         send_access(OP_DECODED, pick_address(1'b0), DATA_W'($urandom_range(255)));
      end else if (r < 93) begin
         send_access(OP_RAW, pick_address(1'b1), DATA_W'($urandom_range(255)));
      end else if (r < 96) begin
         case ($urandom_range(4))
            0:       src = 8'hC0;
            1:       src = 8'hFF;
            2:       src = 8'hFE;
            default: src = DATA_W'($urandom_range(255));
         endcase
         // A copy may only read bytes that were written; the filled page always qualifies.
         if (!page_known(src)) src = 8'hC0;
         send_access(OP_DECODED, ADDR_DMA, src);
      end else begin
         send_access(OP_UNUSED, ADDR_W'($urandom_range(16'hFFFF)),
                     DATA_W'($urandom_range(255)));
      end
   endtask

   task automatic test_power_up_defaults();
      send_access(OP_READ, ADDR_TIMERCTL, 8'hFF);
      send_access(OP_READ, 16'hFF26, 8'h00);
      send_access(OP_READ, 16'hFFFF, 8'h00);
   endtask

   task automatic test_io_side_effects();
      send_access(OP_DECODED, ADDR_LINE, 8'hFF);
      send_access(OP_READ, ADDR_LINE, 8'h00);
      send_access(OP_DECODED, ADDR_DIVIDER, 8'hAB);
      send_access(OP_READ, ADDR_DIVIDER, 8'h00);
   endtask

   task automatic test_timer_control();
      send_access(OP_DECODED, ADDR_TIMERCTL, 8'h01);
      // Same low bits as before: the byte is stored but the period does not change.
      send_access(OP_DECODED, ADDR_TIMERCTL, 8'hFD);
      send_access(OP_DECODED, ADDR_TIMERCTL, 8'h03);
      send_access(OP_DECODED, ADDR_TIMERCTL, 8'h00);
      send_access(OP_READ, ADDR_TIMERCTL, 8'h00);
   endtask

   task automatic test_address_windows();
      send_access(OP_DECODED, 16'h0000, 8'hFF);
      send_access(OP_RAW, 16'h7FFF, 8'h5A);
      send_access(OP_DECODED, 16'h7FFF, 8'hA5);
      send_access(OP_READ, 16'h7FFF, 8'h00);
      send_access(OP_DECODED, ECHO_LAST, 8'h3C);
      send_access(OP_READ, ECHO_LAST - ECHO_OFFSET, 8'h00);
      send_access(OP_RAW, LOCK_LO, 8'h11);
      send_access(OP_DECODED, LOCK_LO, 8'h22);
      send_access(OP_READ, LOCK_LO, 8'h00);
      send_access(OP_DECODED, 16'hFEFF, 8'h44);
      send_access(OP_READ, 16'hFEFF, 8'h00);
   endtask

   task automatic test_dma_copy();
      int k;
      // Fill the first 160 bytes of the source page so that the copy reads only written bytes.
      send_access(OP_RAW, 16'hC000, 8'h88);
      for (k = 1; k < SPRITE_LEN - 1; k++) begin
         send_access(OP_RAW, 16'hC000 + k[ADDR_W-1:0], DATA_W'($urandom_range(255)));
      end
      send_access(OP_RAW, 16'hC09F, 8'h77);
      send_access(OP_DECODED, ADDR_DMA, 8'hC0);
      send_access(OP_READ, SPRITE_BASE, 8'h00);
      send_access(OP_READ, ADDR_W'(SPRITE_BASE + SPRITE_LEN - 1), 8'h00);
      send_access(OP_UNUSED, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_random_traffic();
      int n;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == STEADY_ITEMS) begin
            req_idle_on = 1'b1;
            rsp_idle_on = 1'b1;
         end
         random_access();
      end
   endtask

   // The response side stops for a long time while requests keep coming.
   task automatic test_response_stall();
      int n;
      req_idle_on = 1'b0;
      hold_cycles = STALL_CYCLES;
      for (n = 0; n < STALL_ITEMS; n++) begin
         if (n % 2 == 0) send_access(OP_DECODED, ADDR_W'(16'hC000 + $urandom_range(255)),
                                     DATA_W'($urandom_range(255)));
         else send_access(OP_READ, pick_known_address(), DATA_W'($urandom_range(255)));
      end
      req_idle_on = 1'b1;
   endtask

   initial begin
      int a;
      for (a = 0; a < INIT_COUNT; a++) store_byte(INIT_ADDR[a], INIT_VAL[a], 1'b1);
      period_now = PERIOD_RESET;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_READ;
      req_bus.address    <= '0;
      req_bus.write_data <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_power_up_defaults();
      test_io_side_effects();
      test_timer_control();
      test_address_windows();
      test_dma_copy();
      test_random_traffic();
      test_response_stall();
      test_random_traffic();
      req_bus.valid <= 1'b0;

      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_responses.size() != 0) begin
         $error("%0d expected response items never arrived", pending_responses.size());
         mismatch_count++;
      end
      $display("Ran %0d accesses: %0d reads, %0d sprite DMA copies, %0d timer period changes.",
               accepted_count, read_count, dma_count, change_count);
      $display("Traffic covered every address window, with and without idling and one long stall.");
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Response side: random idling, or a counted hold-off when one is requested.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles--;
         end else if (rsp_idle_on) begin
            rsp_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compares each response item with the oldest prediction.
   always @(posedge clock) begin
      access_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_responses.size() == 0) begin
            $error("response item arrived with no access outstanding");
            mismatch_count++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_bus.read_data !== want.read_data) begin
               $error("read_data expected %0h actual %0h", want.read_data, rsp_bus.read_data);
               mismatch_count++;
            end
            if (rsp_bus.timer_period !== want.timer_period) begin
               $error("timer_period expected %0d actual %0d", want.timer_period,
                      rsp_bus.timer_period);
               mismatch_count++;
            end
            if (rsp_bus.period_changed !== want.period_changed) begin
               $error("period_changed expected %0b actual %0b", want.period_changed,
                      rsp_bus.period_changed);
               mismatch_count++;
            end
         end
      end
   end

   // Ends the run when neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
         $error("no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

// ===== files.f =====
design/mmwd_pkg.sv
design/mmwd_if.sv
design/mmwd_front.sv
design/mmwd_queue.sv
design/mmwd_back.sv
design/handheld_memory_map_write_decoder_top.sv
tb/sv/testbench.sv
